// File: rtl/framed_command_packet_parser_core_defines.svh
// Assertion macros for the framed command packet parser.
// Used by the top level; needs nothing else.
`ifndef FRAMED_COMMAND_PACKET_PARSER_CORE_DEFINES_SVH
`define FRAMED_COMMAND_PACKET_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define FCP_ASSERT_NOW(label, clk, rst_n, cond, conc, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (conc)) \
		else $error(msg);

// Next-cycle implication, checked on every clock edge out of reset.
`define FCP_ASSERT_NEXT(label, clk, rst_n, cond, conc, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (conc)) \
		else $error(msg);

`endif

// File: rtl/fcp_pkg.sv
// Shared types and constants for the framed command packet parser.
// No dependencies.
package fcp_pkg;

	localparam int PAYLOAD_LEN = 5;
	localparam int PosW = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1;

	localparam logic [7:0] HEADER_RESET  = 8'hFF;
	localparam logic [7:0] TRAILER_RESET = 8'hFE;

	localparam logic [1:0] CFG_HEADER  = 2'd0;
	localparam logic [1:0] CFG_TRAILER = 2'd1;

	localparam logic [7:0] CMD_FORWARD = 8'h00;
	localparam logic [7:0] CMD_MOVE    = 8'h01;
	localparam logic [7:0] CMD_BACK    = 8'h02;
	localparam logic [7:0] CMD_LEFT    = 8'h03;
	localparam logic [7:0] CMD_RIGHT   = 8'h04;
	localparam logic [7:0] CMD_STOP    = 8'hFF;
	localparam logic [7:0] CMD_LINK    = 8'h1F;

	localparam logic [10:0] VALUE_MAX = 11'd1665;

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_TRAILER = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		ACT_FORWARD = 3'd0,
		ACT_MOVE    = 3'd1,
		ACT_BACK    = 3'd2,
		ACT_LEFT    = 3'd3,
		ACT_RIGHT   = 3'd4,
		ACT_STOP    = 3'd5,
		ACT_LINK    = 3'd6,
		ACT_UNKNOWN = 3'd7
	} act_t;

	typedef logic [PAYLOAD_LEN-1:0][7:0] payload_t;

	typedef struct packed {
		logic [7:0]  command;
		act_t        action;
		logic [10:0] x_value;
		logic [10:0] y_value;
		logic [7:0]  spare_byte;
	} res_t;

endpackage

// File: rtl/fcp_deframer.sv
// Phase machine and payload store of the packet parser.
// Depends on fcp_pkg.
module fcp_deframer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          rx_byte,
	input  logic [7:0]          header_byte,
	input  logic [7:0]          trailer_byte,
	output fcp_pkg::payload_t   payload,
	output logic                push
);
	import fcp_pkg::*;

	localparam logic [PosW-1:0] LastPos = PosW'(PAYLOAD_LEN - 1);

	phase_t          phase_q, phase_d;
	logic [PosW-1:0] pos_q, pos_d;
	payload_t        store_q;

	// next state
	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		if (accept) begin
			case (phase_q)
				PH_PAYLOAD: begin
					pos_d = pos_q + PosW'(1);
					if (pos_q == LastPos) phase_d = PH_TRAILER;
				end
				PH_TRAILER: begin
					if (rx_byte == trailer_byte) phase_d = PH_HUNT;
				end
				default: begin
					if (rx_byte == header_byte) begin
						phase_d = PH_PAYLOAD;
						pos_d   = '0;
					end else begin
						phase_d = PH_HUNT;
					end
				end
			endcase
		end
	end

	// outputs
	always_comb begin
		case (phase_q)
			PH_TRAILER: push = accept && (rx_byte == trailer_byte);
			default:    push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			pos_q   <= '0;
		end else begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && phase_q == PH_PAYLOAD) store_q[pos_q] <= rx_byte;
	end

	assign payload = store_q;

endmodule

// File: rtl/fcp_decode.sv
// Result decode: action lookup and packed-decimal conversion.
// Depends on fcp_pkg.
module fcp_decode (
	input  fcp_pkg::payload_t payload,
	output fcp_pkg::res_t     res
);
	import fcp_pkg::*;

	logic [7:0] p0, p1, p2, p3;
	act_t       act;

	assign p0 = payload[0];
	assign p1 = payload[1];
	assign p2 = payload[2];
	assign p3 = payload[3];

	always_comb begin
		case (p0)
			CMD_FORWARD: act = ACT_FORWARD;
			CMD_MOVE:    act = ACT_MOVE;
			CMD_BACK:    act = ACT_BACK;
			CMD_LEFT:    act = ACT_LEFT;
			CMD_RIGHT:   act = ACT_RIGHT;
			CMD_STOP:    act = ACT_STOP;
			CMD_LINK:    act = ACT_LINK;
			default:     act = ACT_UNKNOWN;
		endcase
	end

	assign res.command = p0;
	assign res.action  = act;
	// hundreds*100 + tens*10 + units; nibbles are taken as they come
	assign res.x_value = 11'(p1[7:4]) * 11'd100 + 11'(p1[3:0]) * 11'd10 + 11'(p2[7:4]);
	assign res.y_value = 11'(p2[3:0]) * 11'd100 + 11'(p3[7:4]) * 11'd10 + 11'(p3[3:0]);

	// fifth byte exists only for payloads longer than four
	generate
		if (PAYLOAD_LEN > 4) begin : g_spare
			assign res.spare_byte = payload[4];
		end else begin : g_no_spare
			assign res.spare_byte = 8'h00;
		end
	endgenerate

endmodule

// File: rtl/fcp_out_buf.sv
// Two-entry result buffer: output register plus skid register.
// Depends on fcp_pkg.
module fcp_out_buf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  fcp_pkg::res_t  push_res,
	output logic           room,
	output logic           out_valid,
	input  logic           out_ready,
	output fcp_pkg::res_t  out_res
);
	import fcp_pkg::*;

	logic out_valid_q, skid_valid_q;
	res_t out_q, skid_q;
	logic pop;

	assign pop       = out_valid_q && out_ready;
	assign room      = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) skid_valid_q <= 1'b0;
		end else if (push) begin
			if (out_valid_q && !pop) skid_valid_q <= 1'b1;
			else out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) out_q <= skid_q;
		end else if (push) begin
			if (out_valid_q && !pop) skid_q <= push_res;
			else out_q <= push_res;
		end
	end

endmodule

// File: rtl/framed_command_packet_parser_core.sv
// A result is registered when its trailer item is accepted (into the skid register if output is held).
// Throughput: one item per cycle; in_ready drops only when both entries of
// the two-entry result buffer are full (output register and skid register).
// Reset (arst_n low, asynchronous): hunt for the header, empty the buffer,
// header_byte to 0xFF and trailer_byte to 0xFE. The payload store is not cleared.
module framed_command_packet_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  command,
	output logic [2:0]  action,
	output logic [10:0] x_value,
	output logic [10:0] y_value,
	output logic [7:0]  spare_byte,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import fcp_pkg::*;

	`include "framed_command_packet_parser_core_defines.svh"

	logic [7:0] header_q, trailer_q;
	logic       in_acc;
	logic       push;
	logic       room;
	payload_t   payload;
	res_t       dec_res, out_res;

	// Registers accept a write every cycle; out-of-range indexes drop.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q  <= HEADER_RESET;
			trailer_q <= TRAILER_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_HEADER:  header_q  <= cfg_data;
				CFG_TRAILER: trailer_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Hold input while the buffer cannot take another result. Every item
	// may produce one, so readiness follows buffer room only.
	assign in_ready = room;
	assign in_acc   = in_valid && in_ready;

	// Phase machine: hunt for header, store payload, wait for trailer.
	fcp_deframer u_deframer (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (in_acc),
		.rx_byte      (rx_byte),
		.header_byte  (header_q),
		.trailer_byte (trailer_q),
		.payload      (payload),
		.push         (push)
	);

	// Decode straight from the stored payload; every byte it reads was
	// written before the trailer could be matched.
	fcp_decode u_decode (
		.payload (payload),
		.res     (dec_res)
	);

	// Register the result; the skid entry lets input advance under stall.
	fcp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_res  (dec_res),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign command    = out_res.command;
	assign action     = out_res.action;
	assign x_value    = out_res.x_value;
	assign y_value    = out_res.y_value;
	assign spare_byte = out_res.spare_byte;

	`FCP_ASSERT_NEXT(a_push_shows, clk, arst_n, push, out_valid, "result pushed but not shown")
	`FCP_ASSERT_NOW(a_stall_has_out, clk, arst_n, !in_ready, out_valid, "input stalled with empty output")
	`FCP_ASSERT_NOW(a_x_range, clk, arst_n, out_valid, x_value <= VALUE_MAX, "x_value out of range")
	`FCP_ASSERT_NOW(a_y_range, clk, arst_n, out_valid, y_value <= VALUE_MAX, "y_value out of range")

endmodule
